// ===== src/scba_pkg.sv =====
// Package for the size-class bitmap allocator: payload structs, status codes and constants.
// No dependencies.
package scba_pkg;

    localparam int unsigned WORDS_PER_CLASS = 64;
    localparam int unsigned WORD_BITS       = 64;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BADSIZE = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_NOTALLOC = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [11:0] req_size;
        logic [11:0] free_slot;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  size_class;
        logic [11:0] slot_index;
        logic [2:0]  page_index;
        logic [11:0] byte_offset;
        logic        page_needed;
        logic        page_released;
        logic [12:0] used_after;
    } t_rsp;

endpackage

// ===== src/scba_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// No dependencies.
module scba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 576
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/size_class_bitmap_allocator.sv =====
// Top level of the size-class bitmap allocator: request decode, bitmap scan sequencer.
// Uses scba_pkg and scba_ram.
//
// One request at a time. After reset, a clearing pass writes zero to every bitmap word before
// the first request is taken. An allocate reads the class bitmap one word per cycle, starting
// at word 0, until a word with a clear bit below the capacity turns up. It then writes that
// word back. When the slot opens a page other than page 0, it also reads that page's words,
// each in a read state and then a check state. The scan covers up to 64 words and the page
// check up to 8 page words. A free reads the slot's word and writes it back. For a page other
// than page 0 it then checks the page words. A free of a clear slot answers without a write
// back. Bad sizes, empty classes, full classes and frees beyond the capacity answer straight
// from the input decode, without a bitmap read. The result sits in an output register that
// also stalls the input, so the next request is taken in the cycle after the result transfer.
module size_class_bitmap_allocator #(
    parameter int NUM_CLASSES = 9,
    parameter int PAGE_BYTES  = 4096,
    parameter int MAX_PAGES   = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  scba_pkg::t_req  i_req,
    output logic            o_valid,
    input  logic            i_stall,
    output scba_pkg::t_rsp  o_rsp
);
    import scba_pkg::*;

    localparam int DEPTH  = NUM_CLASSES * WORDS_PER_CLASS;
    localparam int AW     = $clog2(DEPTH);
    localparam int PB_LOG = $clog2(PAGE_BYTES);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_FRD   = 4'd3;
    localparam logic [3:0] S_WB    = 4'd4;
    localparam logic [3:0] S_PRD   = 4'd5;
    localparam logic [3:0] S_PCHK  = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    logic [3:0]  r_state;
    logic [AW-1:0] r_clr;
    logic        r_cmd;
    logic [3:0]  r_cls;
    logic [11:0] r_slot;
    logic [5:0]  r_widx;      // word index being scanned
    logic [12:0] r_cap;
    logic [5:0]  r_pw_cnt;    // page words remaining
    logic [5:0]  r_pw;        // current page word
    logic [63:0] r_pmask;     // bit mask for partial page word
    logic        r_pempty;
    logic        r_pgchk;
    logic [63:0] r_word;
    t_rsp        r_rsp;
    logic        r_ovalid;
    logic [12:0] r_used [NUM_CLASSES];

    // memory port signals
    logic          m_we;
    logic [AW-1:0] m_waddr, m_raddr;
    logic [63:0]   m_wdata, m_rdata;

    scba_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_waddr(m_waddr),
        .i_wdata(m_wdata),
        .i_raddr(m_raddr),
        .o_rdata(m_rdata)
    );

    // size decode: class = ceil(log2(size)) - 3, at least 0
    logic [3:0] d_cls;
    logic       d_bad;
    always_comb begin
        d_cls = 4'd0;
        for (int k = 8; k >= 0; k--) begin
            if ((12'd8 << k) >= i_req.req_size) d_cls = 4'(k);
        end
        d_bad = (i_req.req_size == 12'd0) || (i_req.req_size > 12'd2048)
              || (32'(d_cls) >= NUM_CLASSES);
    end

    // per-class geometry: per_page = PAGE_BYTES >> (c+3), at least 1
    function automatic logic [3:0] pp_log(input logic [3:0] c);
        int v;
        v = PB_LOG - 3 - int'(c);
        return (v > 0) ? 4'(v) : 4'd0;
    endfunction

    function automatic logic [12:0] cap_of(input logic [3:0] c);
        logic [13:0] v;
        v = 14'(MAX_PAGES) << pp_log(c);
        return (v > 14'd4096) ? 13'd4096 : 13'(v);
    endfunction

    // answer known at the input transfer: bad size, empty or full class, slot out of range
    t_rsp        a_rsp;
    logic        a_done;
    logic [12:0] a_cap, a_used;
    always_comb begin
        a_cap  = cap_of(d_cls);
        a_used = r_used[d_cls];
        a_rsp  = '0;
        a_done = 1'b1;
        if (d_bad) begin
            a_rsp.status = ST_BADSIZE;
        end else begin
            a_rsp.size_class = d_cls;
            a_rsp.used_after = a_used;
            if (i_req.cmd == CMD_ALLOC) begin
                if (a_used >= a_cap) begin
                    a_rsp.status = ST_FULL;
                end else begin
                    a_done = 1'b0;
                end
            end else if (a_used == 13'd0) begin
                a_rsp.status = ST_EMPTY;
            end else if ({1'b0, i_req.free_slot} >= a_cap) begin
                a_rsp.status     = ST_NOTALLOC;
                a_rsp.slot_index = i_req.free_slot;
            end else begin
                a_done = 1'b0;
            end
        end
    end

    logic [3:0]  c_ppl;
    logic [12:0] c_used;
    assign c_ppl  = pp_log(r_cls);
    assign c_used = r_used[r_cls];

    // first clear bit in the word read
    logic        f_found;
    logic [5:0]  f_bit;
    always_comb begin
        f_found = 1'b0;
        f_bit   = 6'd0;
        for (int b = 63; b >= 0; b--) begin
            if (!m_rdata[b]) begin
                f_found = 1'b1;
                f_bit   = 6'(b);
            end
        end
    end

    logic [11:0] f_slot;
    assign f_slot = {r_widx, f_bit};

    // page words covering the slot's page
    logic [11:0] pg_of, off_of;
    logic [2:0]  pgidx;
    logic [11:0] pg_start;
    logic [12:0] pg_words;
    always_comb begin
        pg_of    = r_slot >> c_ppl;
        pgidx    = 3'(pg_of);
        off_of   = r_slot & ((12'd1 << c_ppl) - 12'd1);
        pg_start = pg_of << c_ppl;
        pg_words = (13'd1 << c_ppl) >> 6;
    end

    logic [63:0] pm_full;
    assign pm_full = (c_ppl >= 4'd6) ? {64{1'b1}}
                   : (((64'd1 << (7'd1 << c_ppl)) - 64'd1) << pg_start[5:0]);

    // page check ignores the slot's own bit: alloc has set it already
    logic [63:0] own_mask;
    assign own_mask = (r_pw == r_slot[11:6]) ? ~(64'd1 << r_slot[5:0]) : {64{1'b1}};

    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;

    logic [AW-1:0] base;
    assign base = AW'(32'(r_cls) * WORDS_PER_CLASS);

    // memory address / write control
    always_comb begin
        m_we    = 1'b0;
        m_waddr = base + AW'(r_slot[11:6]);
        m_wdata = r_word;
        m_raddr = base + AW'(r_widx);
        if (r_state == S_CLEAR) begin
            m_we    = 1'b1;
            m_waddr = r_clr;
            m_wdata = '0;
        end else if (r_state == S_SCAN) begin
            // next word of the scan, wrapping within the class
            m_raddr = base + AW'(r_widx + 6'd1);
        end else if (r_state == S_WB) begin
            m_we = 1'b1;
            m_raddr = base + AW'(r_pw);
        end else if (r_state == S_PRD) begin
            m_raddr = base + AW'(r_pw);
        end else if (r_state == S_FRD && r_cmd == CMD_FREE) begin
            m_raddr = base + AW'(r_slot[11:6]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) r_used[i] <= '0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (32'(r_clr) == DEPTH - 1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_cmd  <= i_req.cmd;
                        r_cls  <= d_cls;
                        r_slot <= i_req.free_slot;
                        r_cap  <= a_cap;
                        r_widx <= '0;
                        r_rsp  <= a_rsp;
                        if (a_done) begin
                            r_ovalid <= 1'b1;
                        end else begin
                            r_state <= S_FRD;
                        end
                    end
                end
                S_SCAN: begin
                    // word r_widx arrives now; next address already issued for r_widx+1
                    if (f_found && {1'b0, f_slot} < r_cap) begin
                        r_slot  <= f_slot;
                        r_word  <= m_rdata | (64'd1 << f_bit);
                        r_pgchk <= (f_slot != 12'd0)
                                && ((f_slot & ((12'd1 << c_ppl) - 12'd1)) == 12'd0);
                        r_state <= S_WB;
                    end else if ({r_widx, 6'd0} + 13'd64 >= r_cap) begin
                        r_rsp.status <= ST_FULL;
                        r_ovalid     <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_widx <= r_widx + 6'd1;
                    end
                end
                S_FRD: begin
                    // read issued here: word 0 for alloc, the slot word for free
                    if (r_cmd == CMD_ALLOC) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_PCHK;
                        r_pgchk <= 1'b0;
                    end
                end
                S_PCHK: begin
                    if (r_pgchk) begin
                        // page-word check result
                        if ((m_rdata & r_pmask & own_mask) != '0) r_pempty <= 1'b0;
                        if (r_pw_cnt <= 6'd1) begin
                            r_state <= S_OUT;
                        end else begin
                            r_pw_cnt <= r_pw_cnt - 6'd1;
                            r_pw     <= r_pw + 6'd1;
                            r_state  <= S_PRD;
                        end
                    end else if (!m_rdata[r_slot[5:0]]) begin
                        r_rsp.status     <= ST_NOTALLOC;
                        r_rsp.slot_index <= r_slot;
                        r_ovalid         <= 1'b1;
                        r_state          <= S_IDLE;
                    end else begin
                        r_word  <= m_rdata & ~(64'd1 << r_slot[5:0]);
                        r_pgchk <= (pgidx != 3'd0);
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    // write back, then start page check if needed
                    r_rsp.slot_index  <= r_slot;
                    r_rsp.page_index  <= pgidx;
                    r_rsp.byte_offset <= 12'(off_of << (r_cls + 4'd3));
                    if (r_cmd == CMD_ALLOC) begin
                        r_used[r_cls]    <= c_used + 13'd1;
                        r_rsp.used_after <= c_used + 13'd1;
                    end else begin
                        r_used[r_cls]    <= c_used - 13'd1;
                        r_rsp.used_after <= c_used - 13'd1;
                    end
                    r_pempty <= 1'b1;
                    r_pw     <= pg_start[11:6];
                    r_pw_cnt <= (pg_words == 13'd0) ? 6'd1 : 6'(pg_words - 13'd1) + 6'd1;
                    r_pmask  <= pm_full;
                    r_state  <= r_pgchk ? S_PRD : S_OUT;
                end
                S_PRD: begin
                    // read issued for r_pw (after the write back)
                    r_state <= S_PCHK;
                end
                S_OUT: begin
                    if (r_pgchk) begin
                        if (r_cmd == CMD_ALLOC) begin
                            r_rsp.page_needed <= r_pempty;
                        end else begin
                            r_rsp.page_released <= r_pempty;
                        end
                    end
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
